// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the edge manifold checker.
// Active in simulation; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/memc_pkg.sv =====
// Package for the edge manifold checker: state machine type and constants.
// No dependencies.
`default_nettype none
package memc_pkg;
   localparam int BOUNDARY_W    = 12;
   localparam int MANIFOLD_W    = 11;
   localparam int NONMANIFOLD_W = 11;
   localparam int DEGENERATE_W  = 12;
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CHECK = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD0,
      ST_ADD1,
      ST_ADD2,
      ST_SCAN,
      ST_CMP,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== hdl/memc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module memc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write the addressed entry when we is set; the addressed entry is read out registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hdl/mesh_edge_manifold_check.sv =====
// Edge manifold checker. Add: after acceptance, ST_ADD0..ST_ADD2 each write one
// edge to the single-port edge RAM or count it degenerate; a dropped add only
// sets overflow. Check: strobe after a scan of E stored non-degenerate edges
// (each key compared with all earlier keys, one RAM read a cycle); no stall; next
// acceptance in the cycle after the strobe. One strobe per check, none per add.
// Sync active-high reset clears triangle, edge, degenerate counts, overflow, not RAM.
`default_nettype none
`include "assert_macros.svh"
module mesh_edge_manifold_check #(
   parameter int MAX_TRIANGLES = 1024,
   parameter int VERTEX_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_type,
   input  wire logic [31:0] req_vert_first,
   input  wire logic [31:0] req_vert_second,
   input  wire logic [31:0] req_vert_third,
   output logic             rsp_valid,
   output logic [memc_pkg::BOUNDARY_W-1:0]    rsp_boundary_count,
   output logic [memc_pkg::MANIFOLD_W-1:0]    rsp_manifold_count,
   output logic [memc_pkg::NONMANIFOLD_W-1:0] rsp_nonmanifold_count,
   output logic [memc_pkg::DEGENERATE_W-1:0]  rsp_degenerate_count,
   output logic             rsp_overflow
);
   import memc_pkg::*;

   localparam int SLOTS = 3 * MAX_TRIANGLES;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int TW    = $clog2(MAX_TRIANGLES + 1);
   localparam int KW    = 2 * VERTEX_BITS;

   state_type state_ff, state_in;
   logic [TW-1:0] tri_cnt_ff, tri_cnt_in;
   logic [CW-1:0] edge_cnt_ff, edge_cnt_in;
   logic [CW-1:0] deg_ff, deg_in;
   logic          ovf_ff, ovf_in;
   logic [VERTEX_BITS-1:0] va_ff, vb_ff, vc_ff, va_in, vb_in, vc_in;
   // scan: i = current key, j = earlier key being compared
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [KW-1:0] key_ff, key_in;
   logic          dup_ff, dup_in;
   // per-key occurrences: counts of keys with zero, one and two earlier matches
   logic [CW-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in, cnt3_ff, cnt3_in;
   logic [CW-1:0] match_ff, match_in;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [KW-1:0] ram_wdata, ram_rdata;
   logic [VERTEX_BITS-1:0] ea, eb;
   logic          cmp_pend_ff, cmp_pend_in;

   memc_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_edge_ram (
      .clock   (clock),
      .we      (ram_we),
      .addr    (ram_addr),
      .wdata   (ram_wdata),
      .rdata_ff(ram_rdata)
   );

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tri_cnt_ff  <= '0;
         edge_cnt_ff <= '0;
         deg_ff      <= '0;
         ovf_ff      <= 1'b0;
         cmp_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tri_cnt_ff  <= tri_cnt_in;
         edge_cnt_ff <= edge_cnt_in;
         deg_ff      <= deg_in;
         ovf_ff      <= ovf_in;
         cmp_pend_ff <= cmp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      vc_ff    <= vc_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      key_ff   <= key_in;
      dup_ff   <= dup_in;
      cnt1_ff  <= cnt1_in;
      cnt2_ff  <= cnt2_in;
      cnt3_ff  <= cnt3_in;
      match_ff <= match_in;
   end

   // The counts work as follows: for each key i we count matches among keys
   // 0..i-1. match==0 means first of its group (boundary +1); match==1 moves
   // a group from boundary to manifold; match==2 moves manifold to non-manifold.
   always_comb begin
      state_in    = state_ff;
      tri_cnt_in  = tri_cnt_ff;
      edge_cnt_in = edge_cnt_ff;
      deg_in      = deg_ff;
      ovf_in      = ovf_ff;
      va_in = va_ff; vb_in = vb_ff; vc_in = vc_ff;
      i_in = i_ff; j_in = j_ff; key_in = key_ff; dup_in = dup_ff;
      cnt1_in = cnt1_ff; cnt2_in = cnt2_ff; cnt3_in = cnt3_ff; match_in = match_ff;
      cmp_pend_in = 1'b0;
      ram_we = 1'b0;
      ram_addr = edge_cnt_ff[AW-1:0];
      ram_wdata = '0;
      busy = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      ea = va_ff; eb = vb_ff;
      case (state_ff)
         ST_ADD0: begin ea = va_ff; eb = vb_ff; end
         ST_ADD1: begin ea = vb_ff; eb = vc_ff; end
         ST_ADD2: begin ea = vc_ff; eb = va_ff; end
         default: begin ea = va_ff; eb = vb_ff; end
      endcase
      ram_wdata = (ea < eb) ? {ea, eb} : {eb, ea};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_ADD) begin
                  if (tri_cnt_ff >= TW'(MAX_TRIANGLES)) begin
                     ovf_in = 1'b1;
                  end else begin
                     va_in = req_vert_first[VERTEX_BITS-1:0];
                     vb_in = req_vert_second[VERTEX_BITS-1:0];
                     vc_in = req_vert_third[VERTEX_BITS-1:0];
                     tri_cnt_in = tri_cnt_ff + TW'(1);
                     state_in = ST_ADD0;
                  end
               end else begin
                  i_in = '0; cnt1_in = '0; cnt2_in = '0; cnt3_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ADD0, ST_ADD1, ST_ADD2: begin
            // append one edge, or count it degenerate
            if (ea == eb) begin
               deg_in = deg_ff + CW'(1);
            end else begin
               ram_we = 1'b1;
               edge_cnt_in = edge_cnt_ff + CW'(1);
            end
            state_in = (state_ff == ST_ADD0) ? ST_ADD1 :
                       (state_ff == ST_ADD1) ? ST_ADD2 : ST_IDLE;
         end
         ST_SCAN: begin
            // fetch key i
            if (i_ff == edge_cnt_ff) begin
               state_in = ST_DONE;
            end else begin
               ram_addr = i_ff[AW-1:0];
               j_in = '0; match_in = '0; dup_in = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // latch key i on entry; then compare earlier keys one a cycle
            ram_addr = j_ff[AW-1:0];
            cmp_pend_in = (j_ff != i_ff);
            if (dup_ff) begin
               key_in = ram_rdata;
               dup_in = 1'b0;
            end else if (cmp_pend_ff && ram_rdata == key_ff) begin
               match_in = match_ff + CW'(1);
            end
            if (!dup_ff && !cmp_pend_ff && j_ff != '0 || (!dup_ff && j_ff == i_ff)) begin
               if (!cmp_pend_ff) begin
                  case (match_ff)
                     CW'(0): cnt1_in = cnt1_ff + CW'(1);
                     CW'(1): cnt2_in = cnt2_ff + CW'(1);
                     CW'(2): cnt3_in = cnt3_ff + CW'(1);
                     default: ;
                  endcase
                  i_in = i_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end
            if (j_ff != i_ff) begin
               j_in = j_ff + CW'(1);
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // groups: new ones, minus those promoted
      rsp_boundary_count    = BOUNDARY_W'(cnt1_ff - cnt2_ff);
      rsp_manifold_count    = MANIFOLD_W'(cnt2_ff - cnt3_ff);
      rsp_nonmanifold_count = NONMANIFOLD_W'(cnt3_ff);
      rsp_degenerate_count  = DEGENERATE_W'(deg_ff);
      rsp_overflow          = ovf_ff;
   end

   `ASSERT_NEVER(a_edge_bound, clock, reset, edge_cnt_ff > CW'(SLOTS), "edge count overflow")
   `ASSERT_NEVER(a_tri_bound, clock, reset, tri_cnt_ff > TW'(MAX_TRIANGLES), "triangle count overflow")
   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid |=> !busy, "busy after result")
   `ASSERT_CLK(a_ovf_sticky, clock, reset, ovf_ff |=> ovf_ff, "overflow flag cleared")
endmodule
`default_nettype wire
